// ===== design/i2c_seq_pkg.sv =====
// Shared types, codes and sizing constants for the I2C register transfer sequencer.
// Depends on nothing; the core, the top level and the checker import it.
package i2c_seq_pkg;

   // Depth of the transmit byte store (legal range 1 to 16)
   localparam int MAX_BYTES = 16;
   localparam int STORE_AW  = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
   localparam int CNT_W     = $clog2(MAX_BYTES + 1);

   // Item kinds on the request channel
   typedef enum logic [1:0] {
      KIND_BEGIN  = 2'd0,
      KIND_LOAD   = 2'd1,
      KIND_STATUS = 2'd2
   } kind_type;

   // Bus controller status codes, also used as the expected-phase state
   typedef enum logic [3:0] {
      PH_START    = 4'd0,
      PH_RESTART  = 4'd1,
      PH_SLAW_ACK = 4'd2,
      PH_DATW_ACK = 4'd3,
      PH_SLAR_ACK = 4'd4,
      PH_DATR_ACK = 4'd5,
      PH_DATR_NAK = 4'd6,
      PH_IDLE     = 4'd7,
      PH_ERROR    = 4'd8
   } phase_type;

   // Assert-ack flag actions
   typedef enum logic [1:0] {
      ACK_NONE  = 2'd0,
      ACK_SET   = 2'd1,
      ACK_CLEAR = 2'd2
   } ack_type;

   // One request word as held in the input register
   typedef struct packed {
      logic [1:0] kind;
      logic [6:0] slave_addr;
      logic [7:0] reg_addr;
      logic [4:0] byte_count;
      logic       is_read;
      logic [3:0] tx_index;
      logic [7:0] tx_value;
      logic [3:0] status_code;
      logic [7:0] rx_data;
   } req_word_type;

   // One response word as held in the result register
   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       set_start;
      logic       clear_start;
      logic       send_stop;
      logic [1:0] ack_action;
      logic       rx_valid;
      logic [3:0] rx_index;
      logic [7:0] rx_byte;
      logic [3:0] phase;
      logic       done_res;
      logic       failed;
   } rsp_word_type;

   // Transmit store write port
   typedef struct packed {
      logic                en;
      logic [STORE_AW-1:0] addr;
      logic [7:0]          data;
   } store_wr_type;

endpackage

// ===== design/i2c_seq_if.sv =====
// Valid/ready channel interfaces for the request and response words.
// Depends on nothing.
interface i2c_seq_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [6:0] slave_addr;
   logic [7:0] reg_addr;
   logic [4:0] byte_count;
   logic       is_read;
   logic [3:0] tx_index;
   logic [7:0] tx_value;
   logic [3:0] status_code;
   logic [7:0] rx_data;

   modport source (output valid, kind, slave_addr, reg_addr, byte_count, is_read,
                   tx_index, tx_value, status_code, rx_data, input ready);
   modport sink (input valid, kind, slave_addr, reg_addr, byte_count, is_read,
                 tx_index, tx_value, status_code, rx_data, output ready);
endinterface

interface i2c_seq_rsp_if;
   logic       valid;
   logic       ready;
   logic       tx_valid;
   logic [7:0] tx_byte;
   logic       set_start;
   logic       clear_start;
   logic       send_stop;
   logic [1:0] ack_action;
   logic       rx_valid;
   logic [3:0] rx_index;
   logic [7:0] rx_byte;
   logic [3:0] phase;
   logic       done_res;
   logic       failed;

   modport source (output valid, tx_valid, tx_byte, set_start, clear_start, send_stop,
                   ack_action, rx_valid, rx_index, rx_byte, phase, done_res, failed,
                   input ready);
   modport sink (input valid, tx_valid, tx_byte, set_start, clear_start, send_stop,
                 ack_action, rx_valid, rx_index, rx_byte, phase, done_res, failed,
                 output ready);
endinterface

// ===== design/i2c_master_register_transfer_sequencer_unit.sv =====
// I2C master register transfer sequencer. Each request word (begin, load
// transmit byte, or bus controller status) yields exactly one response word
// carrying the controller actions, any received byte and the next expected
// phase. A word is captured in an input register, decoded by one pass of
// the transfer state machine and parked in a result register, which
// offers the response until it is taken. One word is taken every cycle;
// the rate is set by the single-pass state machine step, and the request
// side stalls only while the result register is full and not taken. The
// transmit store is read one step ahead so its registered data is ready
// when the next word is decoded. Sending a transmit byte that was never
// loaded gives an undefined data byte.
module i2c_master_register_transfer_sequencer_unit
   import i2c_seq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   i2c_seq_req_if.sink   req_ch,
   i2c_seq_rsp_if.source rsp_ch
);

   logic                in_valid_ff, in_valid_in;
   req_word_type        in_word_ff, in_word_in;
   logic                out_valid_ff, out_valid_in;
   rsp_word_type        out_word_ff, out_word_in;
   logic                advance;
   logic [STORE_AW-1:0] store_addr;
   logic [7:0]          store_data;
   store_wr_type        store_wr;

   // Move the held word forward when the result slot is free or draining
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   // Input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_word_in  = in_word_ff;
      if (req_ch.ready) begin
         in_valid_in            = req_ch.valid;
         in_word_in.kind        = req_ch.kind;
         in_word_in.slave_addr  = req_ch.slave_addr;
         in_word_in.reg_addr    = req_ch.reg_addr;
         in_word_in.byte_count  = req_ch.byte_count;
         in_word_in.is_read     = req_ch.is_read;
         in_word_in.tx_index    = req_ch.tx_index;
         in_word_in.tx_value    = req_ch.tx_value;
         in_word_in.status_code = req_ch.status_code;
         in_word_in.rx_data     = req_ch.rx_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_word_ff <= in_word_in;
   end

   i2c_seq_store #(
      .WIDTH (8),
      .DEPTH (MAX_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr.en),
      .wr_addr (store_wr.addr),
      .wr_data (store_wr.data),
      .rd_addr (store_addr),
      .rd_data (store_data)
   );

   i2c_seq_core u_core (
      .clock      (clock),
      .reset      (reset),
      .fire       (advance),
      .item       (in_word_ff),
      .store_data (store_data),
      .store_addr (store_addr),
      .store_wr   (store_wr),
      .rsp        (out_word_in)
   );

   // Result register: load on advance, drop once taken
   always_comb begin
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (advance) begin
         out_word_ff <= out_word_in;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.tx_valid    = out_word_ff.tx_valid;
   assign rsp_ch.tx_byte     = out_word_ff.tx_byte;
   assign rsp_ch.set_start   = out_word_ff.set_start;
   assign rsp_ch.clear_start = out_word_ff.clear_start;
   assign rsp_ch.send_stop   = out_word_ff.send_stop;
   assign rsp_ch.ack_action  = out_word_ff.ack_action;
   assign rsp_ch.rx_valid    = out_word_ff.rx_valid;
   assign rsp_ch.rx_index    = out_word_ff.rx_index;
   assign rsp_ch.rx_byte     = out_word_ff.rx_byte;
   assign rsp_ch.phase       = out_word_ff.phase;
   assign rsp_ch.done_res    = out_word_ff.done_res;
   assign rsp_ch.failed      = out_word_ff.failed;

endmodule

// ===== design/i2c_seq_store.sv =====
// Generic single-port-write RAM with a registered read port and write-through.
// Depends on nothing; width and depth come from the instantiating module.
module i2c_seq_store #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write the incoming word; contents are undefined until written
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Register the read word; pass a same-address write straight through
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/i2c_seq_core.sv =====
// Transfer state machine: consumes one request word per fire and forms its response.
// Depends on i2c_seq_pkg; drives the transmit store write port and read address.
module i2c_seq_core
   import i2c_seq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  req_word_type        item,
   input  logic [7:0]          store_data,
   output logic [STORE_AW-1:0] store_addr,
   output store_wr_type        store_wr,
   output rsp_word_type        rsp
);

   phase_type          phase_ff, phase_in;
   logic [CNT_W-1:0]   bytes_done_ff, bytes_done_in;
   logic [6:0]         target_addr_ff, target_addr_in;
   logic [7:0]         target_reg_ff, target_reg_in;
   logic [CNT_W-1:0]   transfer_len_ff, transfer_len_in;
   logic               read_mode_ff, read_mode_in;
   logic [CNT_W-1:0]   count_sat;
   logic               last_byte;
   logic               index_ok;

   // Clamp the requested byte count into 1..MAX_BYTES
   always_comb begin
      if (item.byte_count == 5'd0) begin
         count_sat = CNT_W'(1);
      end else if (32'(item.byte_count) > 32'(MAX_BYTES)) begin
         count_sat = CNT_W'(MAX_BYTES);
      end else begin
         count_sat = CNT_W'(item.byte_count);
      end
   end

   assign index_ok = 32'(item.tx_index) < 32'(MAX_BYTES);

   // Read one step ahead: address the byte the next word will send
   assign store_addr = fire ? bytes_done_in[STORE_AW-1:0] : bytes_done_ff[STORE_AW-1:0];

   // Store write for load words
   always_comb begin
      store_wr.en   = fire && (item.kind == KIND_LOAD) && index_ok;
      store_wr.addr = STORE_AW'(item.tx_index);
      store_wr.data = item.tx_value;
   end

   // Last byte of a read: the next one received gets a NAK
   always_comb begin
      if (phase_ff == PH_DATR_ACK) begin
         last_byte = ((CNT_W + 1)'(bytes_done_ff) + (CNT_W + 1)'(2))
                     == (CNT_W + 1)'(transfer_len_ff);
      end else begin
         last_byte = ((CNT_W + 1)'(bytes_done_ff) + (CNT_W + 1)'(1))
                     == (CNT_W + 1)'(transfer_len_ff);
      end
   end

   // Hold transfer state; advance only when a word is consumed
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         bytes_done_ff   <= '0;
         target_addr_ff  <= '0;
         target_reg_ff   <= '0;
         transfer_len_ff <= CNT_W'(1);
         read_mode_ff    <= 1'b0;
      end else if (fire) begin
         phase_ff        <= phase_in;
         bytes_done_ff   <= bytes_done_in;
         target_addr_ff  <= target_addr_in;
         target_reg_ff   <= target_reg_in;
         transfer_len_ff <= transfer_len_in;
         read_mode_ff    <= read_mode_in;
      end
   end

   // Next state and response
   always_comb begin
      phase_in        = phase_ff;
      bytes_done_in   = bytes_done_ff;
      target_addr_in  = target_addr_ff;
      target_reg_in   = target_reg_ff;
      transfer_len_in = transfer_len_ff;
      read_mode_in    = read_mode_ff;
      rsp             = '0;

      case (item.kind)
         KIND_BEGIN: begin
            target_addr_in  = item.slave_addr;
            target_reg_in   = item.reg_addr;
            transfer_len_in = count_sat;
            read_mode_in    = item.is_read;
            bytes_done_in   = '0;
            phase_in        = PH_START;
            rsp.set_start   = 1'b1;
         end
         KIND_STATUS: begin
            if ((item.status_code != phase_ff) || (item.status_code == PH_ERROR)) begin
               phase_in   = PH_ERROR;
               rsp.failed = 1'b1;
            end else begin
               unique case (phase_ff)
                  PH_START: begin
                     rsp.clear_start = 1'b1;
                     rsp.tx_valid    = 1'b1;
                     rsp.tx_byte     = {target_addr_ff, 1'b0};
                     phase_in        = PH_SLAW_ACK;
                  end
                  PH_SLAW_ACK: begin
                     rsp.tx_valid = 1'b1;
                     rsp.tx_byte  = target_reg_ff;
                     phase_in     = PH_DATW_ACK;
                  end
                  PH_DATW_ACK: begin
                     if (read_mode_ff) begin
                        rsp.set_start = 1'b1;
                        phase_in      = PH_RESTART;
                     end else if (bytes_done_ff < transfer_len_ff) begin
                        rsp.tx_valid  = 1'b1;
                        rsp.tx_byte   = store_data;
                        bytes_done_in = bytes_done_ff + CNT_W'(1);
                     end else begin
                        rsp.send_stop = 1'b1;
                        rsp.done_res  = 1'b1;
                        phase_in      = PH_IDLE;
                     end
                  end
                  PH_RESTART: begin
                     rsp.clear_start = 1'b1;
                     rsp.tx_valid    = 1'b1;
                     rsp.tx_byte     = {target_addr_ff, 1'b1};
                     phase_in        = PH_SLAR_ACK;
                  end
                  PH_SLAR_ACK: begin
                     rsp.ack_action = last_byte ? ACK_CLEAR : ACK_SET;
                     phase_in       = last_byte ? PH_DATR_NAK : PH_DATR_ACK;
                  end
                  PH_DATR_ACK: begin
                     rsp.rx_valid   = 1'b1;
                     rsp.rx_index   = 4'(bytes_done_ff);
                     rsp.rx_byte    = item.rx_data;
                     bytes_done_in  = bytes_done_ff + CNT_W'(1);
                     rsp.ack_action = last_byte ? ACK_CLEAR : ACK_SET;
                     phase_in       = last_byte ? PH_DATR_NAK : PH_DATR_ACK;
                  end
                  PH_DATR_NAK: begin
                     rsp.rx_valid  = 1'b1;
                     rsp.rx_index  = 4'(bytes_done_ff);
                     rsp.rx_byte   = item.rx_data;
                     rsp.send_stop = 1'b1;
                     rsp.done_res  = 1'b1;
                     phase_in      = PH_IDLE;
                  end
                  PH_IDLE: begin
                     phase_in = PH_IDLE;
                  end
                  PH_ERROR: begin
                     phase_in = PH_ERROR;
                  end
                  default: begin
                     phase_in = phase_ff;
                  end
               endcase
            end
         end
         default: begin
            // load words and unused kinds leave the sequence alone
         end
      endcase

      rsp.phase = 4'(phase_in);
   end

endmodule

// ===== design/i2c_seq_checker.sv =====
// Port-level checks on the sequencer's response stream, bound to the top level.
// Depends on i2c_seq_pkg for the phase and ack codes.
module i2c_seq_checker
   import i2c_seq_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_tx_valid,
   input logic       rsp_send_stop,
   input logic       rsp_rx_valid,
   input logic [1:0] rsp_ack_action,
   input logic [3:0] rsp_phase,
   input logic       rsp_done_res,
   input logic       rsp_failed
);

   // Result stays offered until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // A failure always leaves the block in the error phase
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_failed |-> rsp_phase == PH_ERROR && !rsp_tx_valid)
      else $error("failed word not in error phase");

   // A finished transfer issues STOP and returns to idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> rsp_send_stop && rsp_phase == PH_IDLE)
      else $error("done without stop or idle");

   // Received bytes arrive only with a data-read or idle next phase and never with a transmit byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rx_valid |-> !rsp_tx_valid &&
         (rsp_phase == PH_DATR_ACK || rsp_phase == PH_DATR_NAK ||
          rsp_phase == PH_IDLE))
      else $error("received byte in wrong phase");

   // NAK is chosen only when the next phase expects the last byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ack_action == ACK_CLEAR |-> rsp_phase == PH_DATR_NAK)
      else $error("ack cleared outside last read byte");

endmodule

bind i2c_master_register_transfer_sequencer_unit i2c_seq_checker u_i2c_seq_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_tx_valid   (rsp_ch.tx_valid),
   .rsp_send_stop  (rsp_ch.send_stop),
   .rsp_rx_valid   (rsp_ch.rx_valid),
   .rsp_ack_action (rsp_ch.ack_action),
   .rsp_phase      (rsp_ch.phase),
   .rsp_done_res   (rsp_ch.done_res),
   .rsp_failed     (rsp_ch.failed)
);

// ===== verif/i2c_seq_tb_pkg.sv =====
// Scoreboard for the I2C register transfer sequencer: predicts each response
// word from the request words and checks the block's output against it.
// Depends on i2c_seq_pkg for the word layouts, phases, kinds and ack codes.
`timescale 1ns / 1ps

package i2c_seq_tb_pkg;
   import i2c_seq_pkg::*;

   class i2c_xfer_scoreboard;
      // Sequencer state as the block should hold it
      phase_type   next_status;
      logic [4:0]  data_count;
      logic [6:0]  slave;
      logic [7:0]  reg_byte;
      logic [4:0]  length;
      bit          read_dir;
      logic [7:0]  tx_bytes [MAX_BYTES];

      rsp_word_type pending_actions[$];
      int unsigned  mismatches;

      function new();
         next_status = PH_IDLE;
         data_count  = '0;
         slave       = '0;
         reg_byte    = '0;
         length      = 5'd1;
         read_dir    = 1'b0;
         foreach (tx_bytes[i]) tx_bytes[i] = '0;
         mismatches  = 0;
      endfunction

      // Pick ACK or NAK for the next received byte
      function void pick_ack(ref rsp_word_type r);
         if (int'(data_count) + 1 == int'(length)) begin
            r.ack_action = ACK_CLEAR;
            next_status  = PH_DATR_NAK;
         end else begin
            r.ack_action = ACK_SET;
            next_status  = PH_DATR_ACK;
         end
      endfunction

      // Advance the sequence by one accepted request word
      function void take_request(req_word_type w);
         rsp_word_type r;
         logic [4:0]   cnt;
         r = '0;
         case (w.kind)
            KIND_BEGIN: begin
               cnt = w.byte_count;
               if (cnt < 5'd1) cnt = 5'd1;
               if (cnt > MAX_BYTES) cnt = 5'(MAX_BYTES);
               slave       = w.slave_addr;
               reg_byte    = w.reg_addr;
               length      = cnt;
               read_dir    = w.is_read;
               data_count  = '0;
               next_status = PH_START;
               r.set_start = 1'b1;
            end
            KIND_LOAD: begin
               if (w.tx_index < MAX_BYTES) tx_bytes[w.tx_index] = w.tx_value;
            end
            KIND_STATUS: begin
               if (w.status_code != next_status || w.status_code == PH_ERROR) begin
                  next_status = PH_ERROR;
                  r.failed    = 1'b1;
               end else begin
                  case (w.status_code)
                     PH_START: begin
                        r.clear_start = 1'b1;
                        r.tx_valid    = 1'b1;
                        r.tx_byte     = {slave, 1'b0};
                        next_status   = PH_SLAW_ACK;
                     end
                     PH_SLAW_ACK: begin
                        r.tx_valid  = 1'b1;
                        r.tx_byte   = reg_byte;
                        next_status = PH_DATW_ACK;
                     end
                     PH_DATW_ACK: begin
                        if (read_dir) begin
                           r.set_start = 1'b1;
                           next_status = PH_RESTART;
                        end else if (data_count < length) begin
                           r.tx_valid = 1'b1;
                           r.tx_byte  = tx_bytes[data_count[3:0]];
                           data_count = data_count + 5'd1;
                        end else begin
                           r.send_stop = 1'b1;
                           r.done_res  = 1'b1;
                           next_status = PH_IDLE;
                        end
                     end
                     PH_RESTART: begin
                        r.clear_start = 1'b1;
                        r.tx_valid    = 1'b1;
                        r.tx_byte     = {slave, 1'b1};
                        next_status   = PH_SLAR_ACK;
                     end
                     PH_SLAR_ACK: pick_ack(r);
                     PH_DATR_ACK: begin
                        r.rx_valid = 1'b1;
                        r.rx_index = data_count[3:0];
                        r.rx_byte  = w.rx_data;
                        data_count = data_count + 5'd1;
                        pick_ack(r);
                     end
                     PH_DATR_NAK: begin
                        r.rx_valid  = 1'b1;
                        r.rx_index  = data_count[3:0];
                        r.rx_byte   = w.rx_data;
                        r.send_stop = 1'b1;
                        r.done_res  = 1'b1;
                        next_status = PH_IDLE;
                     end
                     default: ;
                  endcase
               end
            end
            default: ;
         endcase
         r.phase = next_status;
         pending_actions.push_back(r);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            if (mismatches < 10)
               $display("mismatch on %s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
         end
      endfunction

      // Check one response word against the oldest prediction
      function void check_response(rsp_word_type got);
         rsp_word_type want;
         if (pending_actions.size() == 0) begin
            if (mismatches < 10) $display("response word with nothing pending: 0x%0h", got);
            mismatches++;
            return;
         end
         want = pending_actions.pop_front();
         compare_field("tx_valid",    want.tx_valid,    got.tx_valid);
         compare_field("tx_byte",     want.tx_byte,     got.tx_byte);
         compare_field("set_start",   want.set_start,   got.set_start);
         compare_field("clear_start", want.clear_start, got.clear_start);
         compare_field("send_stop",   want.send_stop,   got.send_stop);
         compare_field("ack_action",  want.ack_action,  got.ack_action);
         compare_field("rx_valid",    want.rx_valid,    got.rx_valid);
         compare_field("rx_index",    want.rx_index,    got.rx_index);
         compare_field("rx_byte",     want.rx_byte,     got.rx_byte);
         compare_field("phase",       want.phase,       got.phase);
         compare_field("done_res",    want.done_res,    got.done_res);
         compare_field("failed",      want.failed,      got.failed);
      endfunction
   endclass

endpackage

// ===== verif/tb_top.sv =====
// Top-level testbench for i2c_master_register_transfer_sequencer_unit: drives
// directed and random transfer sequences with random idling and back-pressure.
// Depends on i2c_seq_pkg, the channel interfaces and i2c_seq_tb_pkg.
`timescale 1ns / 1ps

module tb_top;
   import i2c_seq_pkg::*;
   import i2c_seq_tb_pkg::*;

   localparam int          PERIOD       = 20;
   localparam int          RANDOM_WORDS = 450;
   localparam int          STALL_CYCLES = 300;
   localparam int          DRAIN_CYCLES = 10;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam logic [1:0]  KIND_UNUSED  = 2'd3;

   logic clock = 1'b0;
   logic reset;

   i2c_seq_req_if req_ch ();
   i2c_seq_rsp_if rsp_ch ();

   i2c_master_register_transfer_sequencer_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   i2c_xfer_scoreboard sb;
   int          send_idle_pct;
   int          recv_idle_pct;
   bit          stall_request;
   bit          loaded [MAX_BYTES];
   int          words_sent;
   int unsigned cycle_count;

   always #(PERIOD / 2) clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL i2c_master_register_transfer_sequencer_unit");
         $finish;
      end
   end

   // Take response words and check them
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_response({rsp_ch.tx_valid, rsp_ch.tx_byte, rsp_ch.set_start,
                            rsp_ch.clear_start, rsp_ch.send_stop, rsp_ch.ack_action,
                            rsp_ch.rx_valid, rsp_ch.rx_index, rsp_ch.rx_byte,
                            rsp_ch.phase, rsp_ch.done_res, rsp_ch.failed});
   end

   // Drive response ready; hold it low for a long stretch on request
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_request) begin
            stall_request = 1'b0;
            hold_left     = STALL_CYCLES;
         end
         if (reset || hold_left > 0) begin
            if (hold_left > 0) hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   function automatic req_word_type noise_word();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[$bits(req_word_type)-1:0];
   endfunction

   // Offer one request word after a random gap; return at the accepting edge
   task automatic send_word(input req_word_type w);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.kind        <= w.kind;
      req_ch.slave_addr  <= w.slave_addr;
      req_ch.reg_addr    <= w.reg_addr;
      req_ch.byte_count  <= w.byte_count;
      req_ch.is_read     <= w.is_read;
      req_ch.tx_index    <= w.tx_index;
      req_ch.tx_value    <= w.tx_value;
      req_ch.status_code <= w.status_code;
      req_ch.rx_data     <= w.rx_data;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
      sb.take_request(w);
      if (w.kind != KIND_UNUSED) words_sent++;
   endtask

   task automatic send_load(input logic [3:0] idx, input logic [7:0] val);
      req_word_type w;
      w          = noise_word();
      w.kind     = KIND_LOAD;
      w.tx_index = idx;
      w.tx_value = val;
      loaded[idx] = 1'b1;
      send_word(w);
   endtask

   task automatic send_status(input logic [3:0] code, input logic [7:0] data);
      req_word_type w;
      w             = noise_word();
      w.kind        = KIND_STATUS;
      w.status_code = code;
      w.rx_data     = data;
      send_word(w);
   endtask

   // Begin a transfer; a write first fills any store entry it will send
   task automatic send_begin(input logic [6:0] addr, input logic [7:0] rb,
                             input logic [4:0] cnt, input logic rd);
      req_word_type w;
      int fill;
      fill = (cnt == 0) ? 1 : ((cnt > MAX_BYTES) ? MAX_BYTES : int'(cnt));
      if (!rd)
         for (int i = 0; i < fill; i++)
            if (!loaded[i]) send_load(4'(i), 8'($urandom));
      w            = noise_word();
      w.kind       = KIND_BEGIN;
      w.slave_addr = addr;
      w.reg_addr   = rb;
      w.byte_count = cnt;
      w.is_read    = rd;
      send_word(w);
   endtask

   task automatic send_unused();
      req_word_type w;
      w      = noise_word();
      w.kind = KIND_UNUSED;
      send_word(w);
   endtask

   task automatic random_begin();
      logic [4:0] cnt;
      if ($urandom_range(9) == 0)
         cnt = ($urandom_range(1) == 0) ? 5'd0 : 5'($urandom_range(31, 17));
      else
         cnt = 5'($urandom_range(MAX_BYTES, 1));
      send_begin(7'($urandom), 8'($urandom), cnt, 1'($urandom));
   endtask

   initial begin
      int stage;
      int target;
      int pick;
      sb                 = new();
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.kind        = '0;
      req_ch.slave_addr  = '0;
      req_ch.reg_addr    = '0;
      req_ch.byte_count  = '0;
      req_ch.is_read     = 1'b0;
      req_ch.tx_index    = '0;
      req_ch.tx_value    = '0;
      req_ch.status_code = '0;
      req_ch.rx_data     = '0;
      send_idle_pct      = 8;
      recv_idle_pct      = 78;
      stall_request      = 1'b0;
      words_sent         = 0;
      cycle_count        = 0;
      foreach (loaded[i]) loaded[i] = 1'b0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Idle event while idle, unknown kind, then a stray START into error
      send_status(PH_IDLE, 8'h00);
      send_unused();
      send_status(PH_START, 8'hFF);
      // Write with a zero byte count, saturated to one byte
      send_load(4'd0, 8'hFF);
      send_begin(7'h7F, 8'hFF, 5'd0, 1'b0);
      send_status(PH_START, 8'h00);
      send_status(PH_SLAW_ACK, 8'h00);
      send_status(PH_DATW_ACK, 8'h00);
      send_status(PH_DATW_ACK, 8'h00);
      // Oversized read abandoned by a new begin after the repeated START
      send_begin(7'h00, 8'h00, 5'd31, 1'b1);
      send_status(PH_START, 8'h00);
      send_status(PH_SLAW_ACK, 8'h00);
      send_status(PH_DATW_ACK, 8'h00);
      send_status(PH_RESTART, 8'h00);
      send_begin(7'h55, 8'hA5, 5'd2, 1'b1);
      send_status(PH_START, 8'h00);
      send_status(PH_SLAW_ACK, 8'h00);
      send_status(PH_DATW_ACK, 8'h00);
      send_status(PH_RESTART, 8'h00);
      send_status(PH_SLAR_ACK, 8'h00);
      send_status(PH_DATR_ACK, 8'hFF);
      send_status(PH_DATR_NAK, 8'h00);
      // Bus error while idle, then a code past the table while in error
      send_status(PH_ERROR, 8'h5A);
      send_status(4'hF, 8'hA5);

      // Random transfers, mostly well formed with some noise mixed in
      stage  = 0;
      target = words_sent + RANDOM_WORDS;
      while (words_sent < target) begin
         if (stage == 0 && words_sent >= target - (2 * RANDOM_WORDS) / 3) begin
            stage         = 1;
            send_idle_pct = 78;
            recv_idle_pct = 8;
         end else if (stage == 1 && words_sent >= target - RANDOM_WORDS / 3) begin
            stage         = 2;
            send_idle_pct = 0;
            recv_idle_pct = 0;
            stall_request = 1'b1;
         end
         pick = $urandom_range(99);
         if (sb.next_status == PH_IDLE || sb.next_status == PH_ERROR) begin
            if (pick < 70) random_begin();
            else if (pick < 80) send_load(4'($urandom), 8'($urandom));
            else if (pick < 92) send_status(4'($urandom), 8'($urandom));
            else send_unused();
         end else begin
            if (pick < 90) send_status(sb.next_status, 8'($urandom));
            else if (pick < 93) send_load(4'($urandom), 8'($urandom));
            else if (pick < 95) random_begin();
            else if (pick < 98) send_status(4'($urandom), 8'($urandom));
            else send_unused();
         end
      end

      // Drop valid and let the last responses drain
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (sb.pending_actions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.mismatches == 0)
         $display("PASS i2c_master_register_transfer_sequencer_unit");
      else
         $display("FAIL i2c_master_register_transfer_sequencer_unit");
      $finish;
   end

endmodule

// ===== sim.f =====
design/i2c_seq_pkg.sv
design/i2c_seq_if.sv
design/i2c_seq_store.sv
design/i2c_seq_core.sv
design/i2c_master_register_transfer_sequencer_unit.sv
design/i2c_seq_checker.sv
verif/i2c_seq_tb_pkg.sv
verif/tb_top.sv
